// ----- rtl/core/assert_macros.svh -----
// assertion helpers for clocked properties with async reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/u8ld_pkg.sv -----
package u8ld_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned WIN_LEN = 4;
    localparam int unsigned CNT_W   = 3;

    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_TAG  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_TAG  = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_TAG  = 8'hf0;

    localparam logic [CP_W-1:0] MIN2     = 21'd128;
    localparam logic [CP_W-1:0] MIN3     = 21'd2048;
    localparam logic [CP_W-1:0] MIN4     = 21'd65536;
    localparam logic [CP_W-1:0] SURR_LO  = 21'd55296;
    localparam logic [CP_W-1:0] SURR_HI  = 21'd57343;
    localparam logic [CP_W-1:0] CP_MAX   = 21'd1114111;

    typedef struct packed {
        logic load;
        logic emit;
    } u8ld_cmd_t;

    typedef struct packed {
        logic empty;
        logic stall;
        logic drain;
    } u8ld_sts_t;

endpackage

// ----- rtl/core/u8ld_dp.sv -----
module u8ld_dp
    import u8ld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  u8ld_cmd_t         cmd,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              end_of_string,
    output u8ld_sts_t         sts,
    output logic [CP_W-1:0]   code_point,
    output logic              last_of_string
);

    logic [BYTE_W-1:0] window_reg [WIN_LEN];
    logic [BYTE_W-1:0] window_next [WIN_LEN];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              fin_reg;
    logic              fin_next;
    logic [CP_W-1:0]   cp_reg;
    logic [CP_W-1:0]   cp_next;
    logic              last_reg;
    logic              last_next;

    logic [CNT_W-1:0]  seq_len;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  count_after;
    logic [CP_W-1:0]   r2;
    logic [CP_W-1:0]   r3;
    logic [CP_W-1:0]   r4;
    logic              decode_ok;
    logic [CP_W-1:0]   decoded;

    // lead byte classification
    always_comb
    begin
        priority if ((window_reg[0] & LEAD2_MASK) == LEAD2_TAG)
            seq_len = CNT_W'(2);
        else if ((window_reg[0] & LEAD3_MASK) == LEAD3_TAG)
            seq_len = CNT_W'(3);
        else if ((window_reg[0] & LEAD4_MASK) == LEAD4_TAG)
            seq_len = CNT_W'(4);
        else
            seq_len = CNT_W'(1);
    end

    assign r2 = {10'd0, window_reg[0][4:0], window_reg[1][5:0]};
    assign r3 = {5'd0, window_reg[0][3:0], window_reg[1][5:0], window_reg[2][5:0]};
    assign r4 = {window_reg[0][2:0], window_reg[1][5:0], window_reg[2][5:0],
                 window_reg[3][5:0]};

    always_comb
    begin
        decode_ok = 1'b0;
        decoded   = r2;
        if (seq_len <= count_reg)
        begin
            unique case (seq_len)
                CNT_W'(2):
                begin
                    decoded   = r2;
                    decode_ok = (r2 >= MIN2);
                end
                CNT_W'(3):
                begin
                    decoded   = r3;
                    decode_ok = (r3 >= MIN3) && ((r3 < SURR_LO) || (r3 > SURR_HI));
                end
                CNT_W'(4):
                begin
                    decoded   = r4;
                    decode_ok = (r4 >= MIN4) && (r4 <= CP_MAX);
                end
                default:
                begin
                    decoded   = r2;
                    decode_ok = 1'b0;
                end
            endcase
        end
    end

    assign used        = decode_ok ? seq_len : CNT_W'(1);
    assign count_after = count_reg - used;

    assign sts.empty = (count_reg == '0);
    assign sts.stall = (seq_len > CNT_W'(1)) && (seq_len > count_reg) && !fin_reg;
    assign sts.drain = (count_after == '0);

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        fin_next    = fin_reg;
        cp_next     = cp_reg;
        last_next   = last_reg;
        if (cmd.load)
        begin
            window_next[count_reg[1:0]] = byte_in;
            count_next                  = count_reg + CNT_W'(1);
            fin_next                    = end_of_string;
        end
        else if (cmd.emit)
        begin
            cp_next    = decode_ok ? decoded : {13'd0, window_reg[0]};
            last_next  = fin_reg && (count_after == '0);
            count_next = count_after;
            unique case (used)
                CNT_W'(2):
                begin
                    window_next[0] = window_reg[2];
                    window_next[1] = window_reg[3];
                end
                CNT_W'(3):
                begin
                    window_next[0] = window_reg[3];
                end
                CNT_W'(4):
                begin
                    window_next = window_reg;
                end
                default:
                begin
                    window_next[0] = window_reg[1];
                    window_next[1] = window_reg[2];
                    window_next[2] = window_reg[3];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        cp_reg     <= cp_next;
        last_reg   <= last_next;
    end

    assign code_point     = cp_reg;
    assign last_of_string = last_reg;

endmodule

// ----- rtl/core/u8ld_ctrl.sv -----
module u8ld_ctrl
    import u8ld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  u8ld_sts_t sts,
    output u8ld_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign cmd.load = in_valid && in_ready;
    assign cmd.emit = (state_reg == ST_WORK) && !sts.empty && !sts.stall && out_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit)
            out_valid_next = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_WORK;
            end
            ST_WORK:
            begin
                if (sts.empty || sts.stall)
                    state_next = ST_IDLE;
                else if (cmd.emit && sts.drain)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/utf8_lenient_decoder.sv -----
// Lenient UTF-8 decoder: takes one byte per word on the slave side, with tlast on the
// final byte of a string, and gives one code point per word on the master side, with
// tlast on the last code point of that string. Bytes that do not form a valid,
// non-overlong, non-surrogate sequence up to 0x10FFFF come out as their own value, and
// the bytes after a rejected lead byte are decoded again; continuation tag bits are not
// checked. Each byte is taken in while the controller is idle; the controller then runs
// decode steps of the four-byte window, one step per cycle while the output register is
// free, each step giving one code point, and goes back to idle when the window empties
// or leaves a sequence waiting for more bytes; it takes no byte while a step is pending.
// A finished code point may wait in the output register while the next byte is taken.
module utf8_lenient_decoder
    import u8ld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // code_point, zero fill
    output logic        m_tlast    // last_of_string
);

    u8ld_cmd_t       cmd;
    u8ld_sts_t       sts;
    logic [CP_W-1:0] code_point;

    u8ld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    u8ld_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .byte_in        (s_tdata),
        .end_of_string  (s_tlast),
        .sts            (sts),
        .code_point     (code_point),
        .last_of_string (m_tlast)
    );

    assign m_tdata = {3'd0, code_point};

endmodule

// ----- rtl/core/u8ld_chk.sv -----
`include "assert_macros.svh"

module u8ld_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output word dropped")
    `ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[23:21] == 3'd0, "pad bits set")
    `ASSERT_SAME(a_cp_range, m_tvalid, m_tdata[20:0] <= 21'h10ffff, "code point out of range")
    `ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "byte taken while busy")

endmodule

bind utf8_lenient_decoder u8ld_chk u_chk (.*);

// ----- verif/tb_utf8_lenient_decoder.sv -----
`timescale 1ns / 1ps

module tb_utf8_lenient_decoder;
    import u8ld_pkg::*;

    typedef logic [7:0] byte_str_t[$];

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } byte_word_t;

    typedef struct {
        logic [CP_W-1:0] code_point;
        logic            last;
    } cp_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    byte_word_t  bytes_to_send[$];
    cp_word_t    code_points_due[$];
    logic [7:0]  held_bytes[3];
    int unsigned held_count = 0;

    byte_word_t  next_byte;
    cp_word_t    due_word;
    bit          byte_taken = 1'b0;
    int unsigned bytes_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned long_hold = 0;
    bit          long_hold_done = 1'b0;
    bit          drain_set = 1'b0;
    bit          drain_now;

    utf8_lenient_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit quiet_tail();
        return bytes_to_send.size() < 40;
    endfunction

    function automatic int unsigned lead_length(input logic [7:0] c);
        if ((c & LEAD2_MASK) == LEAD2_TAG)
            return 2;
        if ((c & LEAD3_MASK) == LEAD3_TAG)
            return 3;
        if ((c & LEAD4_MASK) == LEAD4_TAG)
            return 4;
        return 1;
    endfunction

    // window of up to four bytes, decoded from the front as far as it goes
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]      w[4];
        logic [CP_W-1:0] value;
        logic [CP_W-1:0] cand;
        int unsigned     n;
        int unsigned     pos;
        int unsigned     len;
        int unsigned     used;
        int unsigned     k;
        int unsigned     i;
        bit              ok;
        cp_word_t        word;
        n = held_count;
        for (i = 0; i < n; i++)
            w[i] = held_bytes[i];
        w[n] = b;
        n++;
        pos = 0;
        k = 0;
        while (pos < n)
        begin
            len = lead_length(w[pos]);
            if (len > 1 && len > n - pos && !fin)
                break;
            value = {13'd0, w[pos]};
            used = 1;
            if (len > 1 && len <= n - pos)
            begin
                ok = 1'b0;
                cand = '0;
                case (len)
                    2:
                    begin
                        cand = CP_W'({w[pos][4:0], w[pos+1][5:0]});
                        ok = cand >= MIN2;
                    end
                    3:
                    begin
                        cand = CP_W'({w[pos][3:0], w[pos+1][5:0], w[pos+2][5:0]});
                        ok = cand >= MIN3 && (cand < SURR_LO || cand > SURR_HI);
                    end
                    default:
                    begin
                        cand = {w[pos][2:0], w[pos+1][5:0], w[pos+2][5:0],
                                w[pos+3][5:0]};
                        ok = cand >= MIN4 && cand <= CP_MAX;
                    end
                endcase
                if (ok)
                begin
                    value = cand;
                    used = len;
                end
            end
            word.code_point = value;
            word.last = 1'b0;
            code_points_due.insert(code_points_due.size(), word);
            k++;
            pos += used;
        end
        if (fin && k > 0)
            code_points_due[code_points_due.size()-1].last = 1'b1;
        held_count = 0;
        if (!fin)
        begin
            for (i = 0; pos + i < n; i++)
                held_bytes[i] = w[pos+i];
            held_count = n - pos;
        end
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic push_string(input byte_str_t str, input bit drain_first);
        byte_word_t item;
        for (int i = 0; i < str.size(); i++)
        begin
            item.data = str[i];
            item.last = (i == str.size() - 1);
            item.drain_first = drain_first && (i == 0);
            bytes_to_send.insert(bytes_to_send.size(), item);
        end
    endtask

    task automatic push_random_string(input bit drain_first);
        byte_str_t       str;
        logic [CP_W-1:0] cp;
        logic [7:0]      lead;
        int unsigned     len;
        repeat ($urandom_range(1, 10))
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    str.insert(str.size(), 8'($urandom_range(0, 127)));
                2, 3:
                begin
                    cp = CP_W'($urandom_range(128, 2047));
                    str.insert(str.size(), {3'b110, cp[10:6]});
                    str.insert(str.size(), {2'b10, cp[5:0]});
                end
                4, 5:
                begin
                    cp = CP_W'($urandom_range(2048, 65535));
                    str.insert(str.size(), {4'b1110, cp[15:12]});
                    str.insert(str.size(), {2'b10, cp[11:6]});
                    str.insert(str.size(), {2'b10, cp[5:0]});
                end
                6:
                begin
                    cp = CP_W'($urandom_range(65536, 1114111));
                    str.insert(str.size(), {5'b11110, cp[20:18]});
                    str.insert(str.size(), {2'b10, cp[17:12]});
                    str.insert(str.size(), {2'b10, cp[11:6]});
                    str.insert(str.size(), {2'b10, cp[5:0]});
                end
                7:
                    str.insert(str.size(), 8'($urandom_range(0, 255)));
                8:
                begin
                    // lead byte cut short
                    len = $urandom_range(2, 4);
                    case (len)
                        2: lead = 8'hC0 | 8'($urandom_range(0, 31));
                        3: lead = 8'hE0 | 8'($urandom_range(0, 15));
                        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                    endcase
                    str.insert(str.size(), lead);
                    repeat ($urandom_range(0, len - 2))
                        str.insert(str.size(), cont_byte());
                end
                default:
                begin
                    // overlong, surrogate or beyond the last scalar
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            str.insert(str.size(), 8'hC0 | 8'($urandom_range(0, 1)));
                            str.insert(str.size(), cont_byte());
                        end
                        1:
                        begin
                            str.insert(str.size(), 8'hE0);
                            str.insert(str.size(), 8'h80 | 8'($urandom_range(0, 31)));
                            str.insert(str.size(), cont_byte());
                        end
                        2:
                        begin
                            str.insert(str.size(), 8'hED);
                            str.insert(str.size(), 8'hA0 | 8'($urandom_range(0, 31)));
                            str.insert(str.size(), cont_byte());
                        end
                        3:
                        begin
                            str.insert(str.size(), 8'hF0);
                            str.insert(str.size(), 8'h80 | 8'($urandom_range(0, 15)));
                            str.insert(str.size(), cont_byte());
                            str.insert(str.size(), cont_byte());
                        end
                        default:
                        begin
                            str.insert(str.size(), 8'hF4 + 8'($urandom_range(0, 3)));
                            str.insert(str.size(), 8'h90 + 8'($urandom_range(0, 47)));
                            str.insert(str.size(), cont_byte());
                            str.insert(str.size(), cont_byte());
                        end
                    endcase
                end
            endcase
        end
        push_string(str, drain_first);
    endtask

    // sample both sides
    always @(posedge clk)
    begin
        byte_taken = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
                byte_taken = 1'b1;
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (code_points_due.size() == 0)
                begin
                    $error("code_point: expected none, got 0x%06h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    due_word = code_points_due.pop_front();
                    if (m_tdata !== 24'(due_word.code_point))
                    begin
                        $error("code_point: expected 0x%06h, got 0x%06h",
                               due_word.code_point, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== due_word.last)
                    begin
                        $error("last_of_string: expected %0b, got %0b",
                               due_word.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // byte source
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || byte_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (bytes_to_send.size() == 0)
                s_tvalid <= 1'b0;
            else if (bytes_to_send[0].drain_first && code_points_due.size() != 0)
                s_tvalid <= 1'b0;
            else if (!quiet_tail() && $urandom_range(0, 7) == 0)
            begin
                src_gap = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end
            else
            begin
                next_byte = bytes_to_send.pop_front();
                s_tdata <= next_byte.data;
                s_tlast <= next_byte.last;
                s_tvalid <= 1'b1;
            end
        end
    end

    // code point sink
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (long_hold > 0)
        begin
            long_hold--;
            m_tready <= 1'b0;
        end
        else if (!long_hold_done && bytes_taken >= 150)
        begin
            long_hold_done = 1'b1;
            long_hold = 119;
            m_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet_tail() && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        // ascii, top two-byte value, stray continuation and 0xff
        push_string('{8'h00, 8'hDF, 8'hBF, 8'h80, 8'hFF}, 1'b0);
        // overlong two-byte and three-byte forms
        push_string('{8'hC0, 8'hE0, 8'h9F, 8'hBF}, 1'b0);
        // surrogate
        push_string('{8'hED, 8'hA0, 8'h80}, 1'b0);
        // highest scalar, then one past it giving four words at once
        push_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
        // unchecked continuation tag, 0xf8, ascii top, string ends mid sequence
        push_string('{8'hC3, 8'h41, 8'hF8, 8'h7F, 8'hE2, 8'h82}, 1'b0);
        // lone lead byte as a whole string
        push_string('{8'hF0}, 1'b0);
        while (bytes_to_send.size() < 470)
        begin
            drain_now = !drain_set && bytes_to_send.size() >= 280;
            if (drain_now)
                drain_set = 1'b1;
            push_random_string(drain_now);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_to_send.size() != 0 || s_tvalid)
            @(posedge clk);
        while (code_points_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && code_points_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
